// ----- sv/dq_pkg.sv -----
// Shared types for the double-ended queue: op and status codes,
// controller states and the command/status bundles between ctrl and datapath.
// No dependencies.
package dq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4
  } dq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } dq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_FRONT,
    S_RD_BACK,
    S_RD_INDEX,
    S_CAPT,
    S_LOAD
  } dq_state_e;

  typedef enum logic [1:0] {
    RSEL_FRONT,
    RSEL_BACK,
    RSEL_INDEX
  } dq_rsel_e;

  // controller -> datapath
  typedef struct packed {
    logic     take;       // latch the incoming word
    logic     exec;       // apply the operation to pointer, count and RAM
    dq_rsel_e rd_sel;     // RAM read address select
    logic     cap_front;  // RAM data holds the front entry
    logic     cap_back;   // RAM data holds the back entry
    logic     cap_index;  // RAM data holds the indexed entry
    logic     load_out;   // move the result into the output register
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;       // output register can take a result this cycle
  } dq_stat_t;

endpackage

// ----- sv/dq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dq_ctrl.sv -----
// Sequencer for the double-ended queue: accept, execute, three RAM reads,
// then hand the result to the output register.
// Depends on dq_pkg.
module dq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dq_pkg::dq_stat_t  stat_i,
  output dq_pkg::dq_cmd_t   cmd_o
);
  import dq_pkg::*;

  dq_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_EXEC;
      S_EXEC:     state_d = S_RD_FRONT;
      S_RD_FRONT: state_d = S_RD_BACK;
      S_RD_BACK:  state_d = S_RD_INDEX;
      S_RD_INDEX: state_d = S_CAPT;
      S_CAPT:     state_d = S_LOAD;
      S_LOAD:     if (stat_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.rd_sel    = RSEL_FRONT;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      S_EXEC:     cmd_o.exec = 1'b1;
      S_RD_FRONT: cmd_o.rd_sel = RSEL_FRONT;
      S_RD_BACK: begin
        cmd_o.rd_sel    = RSEL_BACK;
        cmd_o.cap_front = 1'b1;
      end
      S_RD_INDEX: begin
        cmd_o.rd_sel   = RSEL_INDEX;
        cmd_o.cap_back = 1'b1;
      end
      S_CAPT:     cmd_o.cap_index = 1'b1;
      S_LOAD:     cmd_o.load_out = stat_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

endmodule

// ----- sv/dq_dpath.sv -----
// Datapath of the double-ended queue: item latch, head pointer, count,
// entry RAM, captured read data and output register.
// Depends on dq_pkg and dq_ram.
module dq_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dq_pkg::dq_cmd_t     cmd_i,
  output dq_pkg::dq_stat_t    stat_o,
  input  logic [2:0]          op_i,
  input  logic signed [31:0]  value_i,
  input  logic [3:0]          index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  front_value_o,
  output logic signed [31:0]  back_value_o,
  output logic signed [31:0]  read_value_o,
  output logic [4:0]          count_o,
  output logic                is_empty_o
);
  import dq_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_P  = AW'(DEPTH - 1);

  // sum of two ring offsets, known to be below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return r[AW-1:0];
  endfunction

  // item latch
  dq_op_e             op_q;
  logic signed [31:0] value_q;
  logic [3:0]         index_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q    <= dq_op_e'(op_i);
      value_q <= value_i;
      index_q <= index_i;
    end
  end

  // ring state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  dq_status_e    st_q, st_d;
  logic          rd_ok_q, rd_ok_d;
  logic          we;
  logic [AW-1:0] waddr;

  logic          full, empty, in_range;
  logic [AW-1:0] tail_pos, head_dec, head_inc;

  assign full     = (cnt_q == DEPTH_C);
  assign empty    = (cnt_q == '0);
  assign in_range = (CMPW'(index_q) < CMPW'(cnt_q));
  assign tail_pos = wrap({1'b0, head_q} + (AW + 1)'(cnt_q));
  assign head_dec = (head_q == '0) ? LAST_P : head_q - AW'(1);
  assign head_inc = (head_q == LAST_P) ? '0 : head_q + AW'(1);

  // operation decode
  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    rd_ok_d = rd_ok_q;
    we      = 1'b0;
    waddr   = tail_pos;
    if (cmd_i.exec) begin
      st_d    = ST_OK;
      rd_ok_d = 1'b0;
      case (op_q)
        OP_PUSH_BACK: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            we    = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            we     = 1'b1;
            waddr  = head_dec;
            head_d = head_dec;
            cnt_d  = cnt_q + CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) st_d = ST_EMPTY;
          else       cnt_d = cnt_q - CW'(1);
        end
        OP_POP_FRONT: begin
          if (empty) begin
            st_d = ST_EMPTY;
          end else begin
            head_d = head_inc;
            cnt_d  = cnt_q - CW'(1);
          end
        end
        OP_READ: begin
          if (in_range) rd_ok_d = 1'b1;
          else          st_d = ST_RANGE;
        end
        default: st_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      cnt_q   <= '0;
      st_q    <= ST_OK;
      rd_ok_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  // read address select
  logic [AW-1:0] raddr;
  logic [AW-1:0] back_off;
  logic [31:0]   rdata;

  assign back_off = AW'(cnt_q - CW'(1));

  always_comb begin
    unique case (cmd_i.rd_sel)
      RSEL_FRONT: raddr = head_q;
      RSEL_BACK:  raddr = wrap({1'b0, head_q} + {1'b0, back_off});
      RSEL_INDEX: raddr = wrap({1'b0, head_q} + (AW + 1)'(index_q));
      default:    raddr = head_q;
    endcase
  end

  dq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // captured read words
  logic signed [31:0] front_q, back_q, idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_front) front_q <= rdata;
    if (cmd_i.cap_back)  back_q  <= rdata;
    if (cmd_i.cap_index) idx_q   <= rdata;
  end

  // output register
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic signed [31:0] fv_q, bv_q, rv_q;
  logic [4:0]         count_q;
  logic               empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q <= st_q;
      fv_q     <= empty ? 32'sd0 : front_q;
      bv_q     <= empty ? 32'sd0 : back_q;
      rv_q     <= rd_ok_q ? idx_q : 32'sd0;
      count_q  <= 5'(cnt_q);
      empty_q  <= empty;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign front_value_o   = fv_q;
  assign back_value_o    = bv_q;
  assign read_value_o    = rv_q;
  assign count_o         = count_q;
  assign is_empty_o      = empty_q;

endmodule

// ----- sv/double_ended_queue.sv -----
// Double-ended queue of signed 32-bit words in a DEPTH-entry RAM ring.
// Each word runs through execute, three reads (front, back, index) on one
// RAM port, capture and load; the next word is taken only after that load.
// A finished result waits in the output register while the next word runs.
// Reset (rst_ni low, async): head and count cleared, no result pending;
// RAM contents are not cleared and need no clearing pass.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic signed [31:0] read_value_o,
  output logic [4:0]         count_o,
  output logic               is_empty_o
);
  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .read_value_o  (read_value_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

// ----- sv/dq_checker.sv -----
// Port-level checks for double_ended_queue, attached by the bind below.
// Depends on dq_pkg.
module dq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [2:0]         op_i,
  input logic signed [31:0] value_i,
  input logic [3:0]         index_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] front_value_o,
  input logic signed [31:0] back_value_o,
  input logic signed [31:0] read_value_o,
  input logic [4:0]         count_o,
  input logic               is_empty_o
);
  import dq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(read_value_o) && $stable(count_o))
    else $error("result changed while stalled");

  // one word at a time: no accept right after an accept
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

  // empty queue shows zero count and zero front/back
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |->
      count_o == 5'd0 && front_value_o == 32'sd0 && back_value_o == 32'sd0)
    else $error("empty result with nonzero fields");

  // a failed word leaves read_value at zero
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == 32'sd0)
    else $error("read value on error status");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
